// ----- design/pwt_pkg.sv -----
// shared types and constants for the periodic window timing block
`default_nettype none
package pwt_pkg;

    localparam int MAX_STARTS = 16;
    localparam int IDX_W = $clog2(MAX_STARTS);
    localparam int CNT_W = $clog2(MAX_STARTS + 1);
    localparam logic [19:0] DAY_SECONDS = 20'd86400;
    localparam logic [19:0] MAX_UNTIL_END = 20'hFFFFF;

    localparam logic [2:0] REG_KIND   = 3'd0;
    localparam logic [2:0] REG_CYCLE  = 3'd1;
    localparam logic [2:0] REG_PHASE  = 3'd2;
    localparam logic [2:0] REG_ACTIVE = 3'd3;
    localparam logic [2:0] REG_COPIES = 3'd4;
    localparam logic [2:0] REG_STARTS = 3'd5;

    localparam logic [1:0] KIND_DAY   = 2'd0;
    localparam logic [1:0] KIND_CYCLE = 2'd1;

    localparam logic [1:0] STAT_WAIT    = 2'd0;
    localparam logic [1:0] STAT_LIVE    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_POS,
        ST_LIST_RD,
        ST_LIST_CHK,
        ST_REP_PHASE,
        ST_REP_STRIDE,
        ST_REP_WALK
    } state_t;

    typedef struct packed {
        logic        go;
        logic [31:0] dividend;
        logic [19:0] divisor;
    } div_req_t;

endpackage
`default_nettype wire

// ----- design/pwt_divider.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module pwt_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pwt_pkg::div_req_t req,
    output logic                  done,
    output logic [31:0]           quotient,
    output logic [19:0]           remainder
);
    import pwt_pkg::*;

    logic        run_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quot_reg;
    logic [19:0] rem_reg;
    logic [19:0] divisor_reg;
    logic [20:0] trial;
    logic [20:0] diff;
    logic        ge;

    assign trial = {rem_reg, quot_reg[31]};
    assign ge    = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[30:0], ge};
            rem_reg  <= ge ? diff[19:0] : trial[19:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ----- design/pwt_start_ram.sv -----
// start offset table, one write and one registered read port
`default_nettype none
module pwt_start_ram (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [pwt_pkg::IDX_W-1:0]  wr_addr,
    input  wire logic [19:0]                wr_data,
    input  wire logic [pwt_pkg::IDX_W-1:0]  rd_addr,
    output logic [19:0]                     rd_data
);
    import pwt_pkg::*;

    logic [19:0] mem [MAX_STARTS];
    logic [19:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- design/periodic_window_timing.sv -----
// top level of the periodic window timing block
// a load word (mode 0) is taken and gives no result. a query
// (mode 1) holds busy while it runs and then pulses done for one cycle with
// status, until_start and until_end. with invalid settings, done comes up
// right after the edge that takes the query and busy never rises. every
// division runs in the shared bit-serial divider. list kinds take one
// division for the time-of-cycle reduction, then one read of the start
// table per start offset examined (states ST_LIST_RD, ST_LIST_CHK). the
// repeat kind runs three divisions (time, phase, stride) and then examines
// the copies in turn. done is high for a single cycle and cannot be held;
// status, until_start and until_end keep their values until the next result.
`default_nettype none
module periodic_window_timing (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [3:0]  slot_index,
    input  wire logic [19:0] start_offset,
    input  wire logic [31:0] now_seconds,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    output logic             done,
    output logic [1:0]       status,
    output logic [20:0]      until_start,
    output logic [19:0]      until_end
);
    import pwt_pkg::*;

    logic [1:0]  kind_reg;
    logic [19:0] cycle_reg;
    logic [19:0] phase_reg;
    logic [19:0] active_reg;
    logic [4:0]  copies_reg;
    logic [4:0]  starts_reg;

    state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [19:0] pos_reg, pos_next;
    logic [19:0] len_reg, len_next;
    logic [19:0] first_reg, first_next;
    logic [19:0] s_reg, s_next;
    logic [19:0] stride_reg, stride_next;
    logic [20:0] best_reg, best_next;
    logic [4:0]  c_reg, c_next;
    logic        done_reg, done_next;
    logic [1:0]  status_reg, status_next;
    logic [20:0] us_reg, us_next;
    logic [19:0] ue_reg, ue_next;

    div_req_t    div_req;
    logic        div_done;
    logic [31:0] div_quot;
    logic [19:0] div_rem;

    logic        accept;
    logic        ram_we;
    logic [19:0] rd_data;

    logic        is_list;
    logic [CNT_W-1:0] n_starts;
    logic [IDX_W-1:0] last_idx;
    logic [4:0]  copies;
    logic        invalid;

    logic [20:0] b_end;
    logic [20:0] live_left;
    logic [20:0] wrap_gap;
    logic [20:0] age_w;
    logic [19:0] age;
    logic [19:0] gap;
    logic [20:0] s_sum;

    assign accept = start && !busy;
    assign ram_we = accept && !mode && ({1'b0, slot_index} < 5'(MAX_STARTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= 2'd2;
            cycle_reg  <= 20'd3600;
            phase_reg  <= 20'd0;
            active_reg <= 20'd900;
            copies_reg <= 5'd1;
            starts_reg <= 5'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KIND:   kind_reg   <= cfg_data[1:0];
                REG_CYCLE:  cycle_reg  <= cfg_data;
                REG_PHASE:  phase_reg  <= cfg_data;
                REG_ACTIVE: active_reg <= cfg_data;
                REG_COPIES: copies_reg <= cfg_data[4:0];
                REG_STARTS: starts_reg <= cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    pwt_start_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (slot_index[IDX_W-1:0]),
        .wr_data (start_offset),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    pwt_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign is_list  = (kind_reg == KIND_DAY) || (kind_reg == KIND_CYCLE);
    assign n_starts = (starts_reg > 5'(MAX_STARTS)) ? CNT_W'(MAX_STARTS)
                                                    : CNT_W'(starts_reg);
    assign last_idx = IDX_W'(n_starts - CNT_W'(1));
    assign copies   = (copies_reg == 5'd0) ? 5'd1 : copies_reg;
    assign invalid  = (active_reg == 20'd0)
                   || (is_list && n_starts == '0)
                   || (kind_reg != KIND_DAY && cycle_reg == 20'd0);

    // list walk arithmetic
    assign b_end     = {1'b0, rd_data} + {1'b0, active_reg};
    assign live_left = b_end - {1'b0, pos_reg};
    assign wrap_gap  = {1'b0, len_reg} - {1'b0, pos_reg} + {1'b0, first_reg};

    // repeat walk arithmetic, s_reg holds the copy start reduced mod cycle
    assign age_w = (pos_reg >= s_reg) ? {1'b0, pos_reg} - {1'b0, s_reg}
                 : {1'b0, pos_reg} + {1'b0, cycle_reg} - {1'b0, s_reg};
    assign age   = age_w[19:0];
    assign gap   = cycle_reg - age;
    assign s_sum = {1'b0, s_reg} + {1'b0, stride_reg};

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        first_next  = first_reg;
        s_next      = s_reg;
        stride_next = stride_reg;
        best_next   = best_reg;
        c_next      = c_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        us_next     = us_reg;
        ue_next     = ue_reg;
        div_req     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode)
                begin
                    if (invalid)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_INVALID;
                        us_next     = '0;
                        ue_next     = '0;
                    end
                    else
                    begin
                        len_next         = (kind_reg == KIND_DAY) ? DAY_SECONDS : cycle_reg;
                        div_req.go       = 1'b1;
                        div_req.dividend = now_seconds;
                        div_req.divisor  = (kind_reg == KIND_DAY) ? DAY_SECONDS : cycle_reg;
                        state_next       = ST_DIV_POS;
                    end
                end
            end
            ST_DIV_POS:
            begin
                if (div_done)
                begin
                    pos_next = div_rem;
                    if (is_list)
                    begin
                        idx_next   = '0;
                        state_next = ST_LIST_RD;
                    end
                    else
                    begin
                        div_req.go       = 1'b1;
                        div_req.dividend = {12'd0, phase_reg};
                        div_req.divisor  = cycle_reg;
                        state_next       = ST_REP_PHASE;
                    end
                end
            end
            ST_LIST_RD:
            begin
                state_next = ST_LIST_CHK;
            end
            ST_LIST_CHK:
            begin
                if (idx_reg == '0)
                begin
                    first_next = rd_data;
                end
                if (pos_reg < rd_data)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_WAIT;
                    us_next     = {1'b0, rd_data - pos_reg};
                    ue_next     = '0;
                    state_next  = ST_IDLE;
                end
                else if ({1'b0, pos_reg} < b_end)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_LIVE;
                    us_next     = '0;
                    ue_next     = live_left[20] ? MAX_UNTIL_END : live_left[19:0];
                    state_next  = ST_IDLE;
                end
                else if (idx_reg == last_idx)
                begin
                    // no window ahead, wrap to the first start of next cycle
                    done_next   = 1'b1;
                    status_next = STAT_WAIT;
                    us_next     = (idx_reg == '0)
                                ? {1'b0, len_reg} - {1'b0, pos_reg} + {1'b0, rd_data}
                                : wrap_gap;
                    ue_next     = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_LIST_RD;
                end
            end
            ST_REP_PHASE:
            begin
                if (div_done)
                begin
                    s_next           = div_rem;
                    div_req.go       = 1'b1;
                    div_req.dividend = {12'd0, cycle_reg};
                    div_req.divisor  = {15'd0, copies};
                    state_next       = ST_REP_STRIDE;
                end
            end
            ST_REP_STRIDE:
            begin
                if (div_done)
                begin
                    stride_next = div_quot[19:0];
                    best_next   = {1'b0, cycle_reg};
                    c_next      = '0;
                    state_next  = ST_REP_WALK;
                end
            end
            ST_REP_WALK:
            begin
                if (age < active_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_LIVE;
                    us_next     = '0;
                    ue_next     = active_reg - age;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    if ({1'b0, gap} < best_reg)
                    begin
                        best_next = {1'b0, gap};
                    end
                    s_next = (s_sum >= {1'b0, cycle_reg})
                           ? 20'(s_sum - {1'b0, cycle_reg}) : s_sum[19:0];
                    c_next = c_reg + 5'd1;
                    if (c_reg == copies - 5'd1)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_WAIT;
                        us_next     = ({1'b0, gap} < best_reg) ? {1'b0, gap} : best_reg;
                        ue_next     = '0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        len_reg    <= len_next;
        first_reg  <= first_next;
        s_reg      <= s_next;
        stride_reg <= stride_next;
        best_reg   <= best_next;
        c_reg      <= c_next;
        status_reg <= status_next;
        us_reg     <= us_next;
        ue_reg     <= ue_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign until_start = us_reg;
    assign until_end   = ue_reg;

endmodule
`default_nettype wire

// ----- dv/pwt_checker.sv -----
// checker for the periodic window timing block: mirrors settings, predicts and compares
`timescale 1ns / 1ps
module pwt_checker
    import pwt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        mode,
    input  wire logic [3:0]  slot_index,
    input  wire logic [19:0] start_offset,
    input  wire logic [31:0] now_seconds,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    input  wire logic        done,
    input  wire logic [1:0]  status,
    input  wire logic [20:0] until_start,
    input  wire logic [19:0] until_end,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [1:0]  status;
        logic [20:0] until_start;
        logic [19:0] until_end;
    } timing_t;

    timing_t     timing_due[$];
    logic [1:0]  kind_q;
    logic [19:0] cycle_q, phase_q, active_q;
    logic [4:0]  copies_q, starts_q;
    logic [19:0] offsets_q [MAX_STARTS];

    function automatic timing_t pack_timing(logic [1:0] st, longint us, longint ue);
        timing_t t;
        if (us < 0) us = 0;
        if (ue < 0) ue = 0;
        if (us > longint'(21'h1FFFFF)) us = longint'(21'h1FFFFF);
        if (ue > longint'(MAX_UNTIL_END)) ue = longint'(MAX_UNTIL_END);
        t.status = st;
        t.until_start = us[20:0];
        t.until_end = ue[19:0];
        return t;
    endfunction

    function automatic timing_t list_window(longint pos, longint len);
        int     n;
        longint act, b;
        n = starts_q;
        act = active_q;
        if (n > MAX_STARTS) n = MAX_STARTS;
        if (n == 0 || act == 0) return pack_timing(STAT_INVALID, 0, 0);
        for (int i = 0; i < n; i++)
        begin
            b = offsets_q[i];
            if (pos < b) return pack_timing(STAT_WAIT, b - pos, 0);
            if (pos < b + act) return pack_timing(STAT_LIVE, 0, b + act - pos);
        end
        return pack_timing(STAT_WAIT, len - pos + longint'(offsets_q[0]), 0);
    endfunction

    function automatic timing_t repeat_window(longint now);
        longint cyc, act, copies, pos, stride, best, st, age;
        cyc = cycle_q;
        act = active_q;
        copies = copies_q;
        if (cyc == 0 || act == 0) return pack_timing(STAT_INVALID, 0, 0);
        if (copies < 1) copies = 1;
        pos = now % cyc;
        stride = cyc / copies;
        best = cyc;
        for (longint c = 0; c < copies; c++)
        begin
            st = longint'(phase_q) + c * stride;
            age = (pos - st) % cyc;
            if (age < 0) age += cyc;
            if (age < act) return pack_timing(STAT_LIVE, 0, act - age);
            if (cyc - age < best) best = cyc - age;
        end
        return pack_timing(STAT_WAIT, best, 0);
    endfunction

    function automatic timing_t window_timing(logic [31:0] now_in);
        longint now;
        now = now_in;
        if (kind_q == KIND_DAY) return list_window(now % 86400, 86400);
        if (kind_q == KIND_CYCLE)
        begin
            if (cycle_q == 0) return pack_timing(STAT_INVALID, 0, 0);
            return list_window(now % longint'(cycle_q), cycle_q);
        end
        return repeat_window(now);
    endfunction

    assign outstanding = timing_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        timing_t want;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            kind_q <= 2'd2;
            cycle_q <= 20'd3600;
            phase_q <= 20'd0;
            active_q <= 20'd900;
            copies_q <= 5'd1;
            starts_q <= 5'd0;
            mismatches <= 0;
            timing_due.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_KIND:   kind_q <= cfg_data[1:0];
                    REG_CYCLE:  cycle_q <= cfg_data;
                    REG_PHASE:  phase_q <= cfg_data;
                    REG_ACTIVE: active_q <= cfg_data;
                    REG_COPIES: copies_q <= cfg_data[4:0];
                    REG_STARTS: starts_q <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (!mode) offsets_q[slot_index] <= start_offset;
                else timing_due.push_back(window_timing(now_seconds));
            end
            if (done)
            begin
                if (timing_due.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errs++;
                end
                else
                begin
                    want = timing_due.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errs++;
                    end
                    if (until_start !== want.until_start)
                    begin
                        $error("until_start: expected %0d, got %0d",
                               want.until_start, until_start);
                        errs++;
                    end
                    if (until_end !== want.until_end)
                    begin
                        $error("until_end: expected %0d, got %0d", want.until_end, until_end);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
        end
    end

endmodule

// ----- dv/tb_periodic_window_timing.sv -----
// stimulus and verdict for the periodic window timing block
`timescale 1ns / 1ps
module tb_periodic_window_timing;
    import pwt_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 160;
    // index past the last register, must be ignored
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic        clk, rst_n, start, mode, cfg_write;
    logic        busy, done;
    logic [3:0]  slot_index;
    logic [19:0] start_offset, cfg_data;
    logic [31:0] now_seconds;
    logic [2:0]  cfg_index;
    logic [1:0]  status;
    logic [20:0] until_start;
    logic [19:0] until_end;
    int          mismatches, outstanding;
    int          cycles = 0;
    int          words_sent = 0;
    int          burst_left = 0;

    // settings and table as last written, used to aim query times at edges
    logic [1:0]  cur_kind;
    logic [19:0] cur_cycle, cur_phase, cur_active;
    logic [19:0] plan [MAX_STARTS];

    periodic_window_timing uut (.*);

    pwt_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_periodic_window_timing: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [19:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_KIND:   cur_kind = data[1:0];
            REG_CYCLE:  cur_cycle = data;
            REG_PHASE:  cur_phase = data;
            REG_ACTIVE: cur_active = data;
            default: ;
        endcase
    endtask

    task automatic send_word(logic m, logic [3:0] s, logic [19:0] off, logic [31:0] now);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                start = 1'b0;
                repeat ($urandom_range(1, 25)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        mode = m;
        slot_index = s;
        start_offset = off;
        now_seconds = now;
        start = 1'b1;
        while (busy) @(negedge clk);
        @(negedge clk);
        if (!m) plan[s] = off;
        words_sent++;
    endtask

    task automatic drain();
        start = 1'b0;
        while (outstanding != 0 || busy) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [31:0] aim_time();
        longint len, target, k;
        int     i;
        len = (cur_kind == KIND_DAY) ? 86400 : ((cur_cycle == 0) ? 1 : cur_cycle);
        i = $urandom_range(0, MAX_STARTS - 1);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: target = longint'(plan[i]) + $urandom_range(0, 2) - 1;
            2: target = longint'(plan[i]) + cur_active + $urandom_range(0, 2) - 1;
            3: target = longint'(cur_phase) + $urandom_range(0, 2) - 1;
            default: target = len - 1 + $urandom_range(0, 1);
        endcase
        k = $urandom_range(0, 32'(32'hFFFFFFFF / len));
        return 32'(k * len + target);
    endfunction

    // ascending table, spread over roughly one cycle
    task automatic load_table(longint len);
        longint acc, step;
        acc = $urandom_range(0, 3);
        step = len / 16 + 1;
        for (int s = 0; s < MAX_STARTS; s++)
        begin
            send_word(1'b0, 4'(s), 20'(acc), $urandom);
            acc += $urandom_range(0, 32'(step));
            if (acc > 20'hFFFFF) acc = 20'hFFFFF;
        end
    endtask

    initial
    begin
        logic [19:0] cyc, act;
        int          n_q;
        start = 1'b0;
        mode = 1'b0;
        slot_index = '0;
        start_offset = '0;
        now_seconds = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_kind = 2'd2;
        cur_cycle = 20'd3600;
        cur_phase = '0;
        cur_active = 20'd900;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every slot first, so no query can read an empty one
        for (int s = 0; s < MAX_STARTS; s++)
            send_word(1'b0, 4'(s), 20'(s * 5000 + 100), 32'd0);
        send_word(1'b1, 4'd0, 20'd0, 32'd0);
        send_word(1'b1, 4'd0, 20'd0, 32'hFFFFFFFF);
        send_word(1'b1, 4'd0, 20'd0, 32'd899);
        send_word(1'b1, 4'd0, 20'd0, 32'd900);
        send_word(1'b1, 4'd0, 20'd0, 32'd3599);
        drain();
        write_reg(REG_KIND, {18'd0, KIND_DAY});
        write_reg(REG_STARTS, 20'd31);
        send_word(1'b1, 4'd0, 20'd0, 32'd50);
        send_word(1'b1, 4'd0, 20'd0, 32'd5150);
        send_word(1'b1, 4'd0, 20'd0, 32'd86399);
        send_word(1'b1, 4'd0, 20'd0, 32'd86400 + 75150);
        drain();
        write_reg(REG_SPARE, 20'hFFFFF);
        write_reg(REG_ACTIVE, 20'd0);
        send_word(1'b1, 4'd0, 20'd0, 32'd10);
        drain();

        for (int ph = 0; words_sent < 1750; ph++)
        begin
            if (ph == 0)
            begin
                cyc = 20'hFFFFF;
                act = 20'hFFFFF;
            end
            else if (ph == 1)
            begin
                cyc = 20'd0;
                act = 20'd0;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: cyc = 20'd0;
                    1: cyc = 20'hFFFFF;
                    2, 3: cyc = 20'($urandom_range(1, 100));
                    4: cyc = 20'($urandom);
                    default: cyc = 20'($urandom_range(100, 100000));
                endcase
                case ($urandom_range(0, 9))
                    0: act = 20'd0;
                    1: act = 20'd1;
                    2: act = 20'hFFFFF;
                    default: act = 20'($urandom_range(1, (cyc == 0) ? 5000 : cyc));
                endcase
            end
            write_reg(REG_KIND, 20'(($urandom & 20'hFFFFC) | $urandom_range(0, 3)));
            write_reg(REG_CYCLE, cyc);
            write_reg(REG_PHASE, (ph == 0) ? 20'hFFFFF : (ph == 1) ? 20'd0 :
                      (($urandom_range(0, 1) != 0) ? 20'($urandom) :
                       20'($urandom_range(0, (cyc == 0) ? 10 : cyc))));
            write_reg(REG_ACTIVE, act);
            write_reg(REG_COPIES, (ph == 0) ? 20'd31 : (ph == 1) ? 20'd0 :
                      20'(($urandom & 20'hFFFE0) | $urandom_range(0, 31)));
            write_reg(REG_STARTS, (ph == 0) ? 20'd31 : (ph == 1) ? 20'd0 :
                      20'(($urandom & 20'hFFFE0) |
                          (($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 16))));
            if ($urandom_range(0, 2) != 0)
                load_table((cur_kind == KIND_DAY) ? 86400 : ((cyc == 0) ? 1000 : cyc));
            n_q = $urandom_range(10, 50);
            for (int q = 0; q < n_q; q++)
            begin
                // occasional stray write breaks the ascending order
                if ($urandom_range(0, 14) == 0)
                    send_word(1'b0, 4'($urandom), 20'($urandom), $urandom);
                else
                    send_word(1'b1, 4'($urandom), 20'($urandom), aim_time());
            end
            drain();
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("tb_periodic_window_timing: done, clean");
        else
            $display("tb_periodic_window_timing: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pwt_pkg.sv
design/pwt_divider.sv
design/pwt_start_ram.sv
design/periodic_window_timing.sv
dv/pwt_checker.sv
dv/tb_periodic_window_timing.sv
